>>> sv/smq_pkg.sv
// Shared types, widths and codes for the suffix maximum query store.
package smq_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int LEN_W    = 11;
    localparam int STAT_W   = 2;
    localparam int CMP_W    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    localparam logic MODE_APPEND = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BAD_WINDOW = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL       = 2'd2;

    localparam logic [1:0] RD_TOP = 2'd0;
    localparam logic [1:0] RD_MID = 2'd1;
    localparam logic [1:0] RD_LO  = 2'd2;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] value;
        logic [LEN_W-1:0]         window_length;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] max_value;
        logic [STAT_W-1:0]        status;
    } rsp_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic [ADDR_W-1:0]        pos;
    } entry_t;

    typedef struct packed {
        logic              capture;
        logic              rd_en;
        logic [1:0]        rd_sel;
        logic              pop;
        logic              push;
        logic              init_search;
        logic              step;
        logic              set_res;
        logic [STAT_W-1:0] res_status;
        logic              load_out;
    } cmd_t;

    typedef struct packed {
        logic is_query;
        logic store_full;
        logic window_bad;
        logic height_zero;
        logic search_done;
        logic top_le;
        logic out_free;
    } sts_t;

endpackage

>>> sv/suffix_max_query_store_unit.sv
// Top level of the suffix maximum query store: controller plus datapath.
// Keeps an append-only sequence of signed values and answers the maximum of the
// most recent window_length values. A monotonic stack of (position, value) pairs
// sits in a single-port memory with registered read; every stack access is a read
// followed by a compare. An append reads the stack top and pops it while its value
// is not greater than the new value, then pushes the new entry; reads stop when the
// stack is empty, and pops are amortized over appends. A query runs a binary search
// through the memory read port for the oldest stack entry inside the window. Rejected
// items (bad window, full store) answer with a status and a zero value. A finished
// result waits in an output register while the next item is accepted.
module suffix_max_query_store_unit import smq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    cmd_t cmd;
    sts_t sts;

    smq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    smq_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule

>>> sv/smq_datapath.sv
// Datapath: item latch, stack memory, search bounds and result registers.
module smq_datapath import smq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  req_t req,
    input  cmd_t cmd,
    output sts_t sts,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    entry_t            mem [CAPACITY];
    req_t              item_reg;
    entry_t            rdata_reg;
    logic [CNT_W-1:0]  height_reg, height_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [ADDR_W-1:0] lo_reg, lo_next;
    logic [ADDR_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0] start_reg;
    logic [ADDR_W-1:0] mid;
    logic [ADDR_W-1:0] rd_addr;
    logic [CMP_W-1:0]  len_ext;
    logic [CMP_W-1:0]  count_ext;
    rsp_t              res_reg;
    rsp_t              rsp_reg;
    logic              rsp_valid_reg, rsp_valid_next;

    assign len_ext   = CMP_W'(item_reg.window_length);
    assign count_ext = CMP_W'(count_reg);
    assign mid       = lo_reg + ((hi_reg - lo_reg) >> 1);

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_TOP:  rd_addr = ADDR_W'(height_reg - CNT_W'(1));
            RD_MID:  rd_addr = mid;
            default: rd_addr = lo_reg;
        endcase
    end

    always_comb
    begin
        sts.is_query    = (item_reg.mode == MODE_QUERY);
        sts.store_full  = (count_reg >= CNT_W'(CAPACITY));
        sts.window_bad  = (item_reg.window_length == '0) || (len_ext > count_ext)
                          || (height_reg == '0);
        sts.height_zero = (height_reg == '0);
        sts.search_done = (lo_reg == hi_reg);
        sts.top_le      = ($signed(rdata_reg.value) <= $signed(item_reg.value));
        sts.out_free    = !rsp_valid_reg || rsp_ready;
    end

    always_comb
    begin
        height_next = height_reg;
        count_next  = count_reg;
        if (cmd.pop)
        begin
            height_next = height_reg - CNT_W'(1);
        end
        if (cmd.push)
        begin
            height_next = height_reg + CNT_W'(1);
            count_next  = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.init_search)
        begin
            lo_next = '0;
            hi_next = ADDR_W'(height_reg - CNT_W'(1));
        end
        else if (cmd.step)
        begin
            if (rdata_reg.pos >= start_reg)
            begin
                hi_next = mid;
            end
            else
            begin
                lo_next = mid + ADDR_W'(1);
            end
        end
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            height_reg    <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            height_reg    <= height_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        if (cmd.capture)
        begin
            item_reg <= req;
        end
        if (cmd.init_search)
        begin
            start_reg <= ADDR_W'(count_ext - len_ext);
        end
        if (cmd.set_res)
        begin
            res_reg.status    <= cmd.res_status;
            res_reg.max_value <= (cmd.res_status == STATUS_OK) ? rdata_reg.value : '0;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= res_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[ADDR_W'(height_reg)] <= '{value: item_reg.value, pos: ADDR_W'(count_reg)};
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> sv/smq_ctrl.sv
// Controller: sequences append pops, push and the binary search of a query.
module smq_ctrl import smq_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_POP_RD  = 4'd2;
    localparam logic [3:0] S_POP_CMP = 4'd3;
    localparam logic [3:0] S_PUSH    = 4'd4;
    localparam logic [3:0] S_SEARCH  = 4'd5;
    localparam logic [3:0] S_STEP    = 4'd6;
    localparam logic [3:0] S_FINAL   = 4'd7;
    localparam logic [3:0] S_RESULT  = 4'd8;

    logic [3:0] state_reg, state_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_TOP;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sts.is_query)
                begin
                    if (sts.window_bad)
                    begin
                        cmd.set_res    = 1'b1;
                        cmd.res_status = STATUS_BAD_WINDOW;
                        state_next     = S_RESULT;
                    end
                    else
                    begin
                        cmd.init_search = 1'b1;
                        state_next      = S_SEARCH;
                    end
                end
                else if (sts.store_full)
                begin
                    cmd.set_res    = 1'b1;
                    cmd.res_status = STATUS_FULL;
                    state_next     = S_RESULT;
                end
                else
                begin
                    state_next = S_POP_RD;
                end
            end
            S_POP_RD:
            begin
                if (sts.height_zero)
                begin
                    state_next = S_PUSH;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_TOP;
                    state_next = S_POP_CMP;
                end
            end
            S_POP_CMP:
            begin
                if (sts.top_le)
                begin
                    cmd.pop    = 1'b1;
                    state_next = S_POP_RD;
                end
                else
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                cmd.push   = 1'b1;
                state_next = S_IDLE;
            end
            S_SEARCH:
            begin
                cmd.rd_en = 1'b1;
                if (sts.search_done)
                begin
                    cmd.rd_sel = RD_LO;
                    state_next = S_FINAL;
                end
                else
                begin
                    cmd.rd_sel = RD_MID;
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = S_SEARCH;
            end
            S_FINAL:
            begin
                cmd.set_res    = 1'b1;
                cmd.res_status = STATUS_OK;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
